// File: rtl/core/sobel_edge_window_defines.svh
// Assertion macros for the Sobel edge window block.
// Used by the top level; no other dependencies.
`ifndef SOBEL_EDGE_WINDOW_DEFINES_SVH
`define SOBEL_EDGE_WINDOW_DEFINES_SVH

`ifndef SYNTHESIS
`define SOBW_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("sobel_edge_window: same-cycle check failed");
`define SOBW_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sobel_edge_window: next-cycle check failed");
`else
`define SOBW_ASSERT_SAME(lbl, pre, post)
`define SOBW_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// File: rtl/core/sobw_pkg.sv
// Shared types and constants of the Sobel edge window block.
// No dependencies.
`default_nettype none

package sobw_pkg;

  localparam int PIX_BITS      = 8;
  localparam int LW_BITS       = 7;
  localparam int FH_BITS       = 12;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int MIN_DIM       = 3;
  localparam int WIN_SPAN      = 2;

  typedef logic [PIX_BITS-1:0] pix_t;

  typedef enum logic {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } sobw_reg_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } sobw_col_t;

  typedef struct packed {
    logic take;
    logic emit;
    logic last;
  } sobw_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/sobw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sobw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/core/sobw_cell.sv
// One window column cell: holds top, middle and bottom pixels of a column.
// Depends on sobw_pkg.
`default_nettype none

module sobw_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  sobw_pkg::sobw_col_t col_in,
  output sobw_pkg::sobw_col_t col_out
);
  import sobw_pkg::*;

  sobw_col_t col_r;
  sobw_col_t col_nxt;

  always_comb begin
    col_nxt = shift_en ? col_in : col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_out = col_r;

endmodule

`default_nettype wire

// File: rtl/core/sobw_kernel.sv
// Sobel kernel sum over the 3x3 window and the output register.
// Depends on sobw_pkg.
`default_nettype none

module sobw_kernel (
  input  logic                clk,
  input  logic                rst_n,
  input  sobw_pkg::sobw_ctl_t ctl,
  input  sobw_pkg::sobw_col_t left_col,
  input  sobw_pkg::sobw_col_t center_col,
  input  sobw_pkg::sobw_col_t right_col,
  input  logic                out_ready,
  output logic                out_valid,
  output sobw_pkg::pix_t      out_edge_value,
  output logic                out_last_of_frame
);
  import sobw_pkg::*;

  pix_t gx;
  pix_t gy;
  pix_t edge_sum;

  logic valid_r;
  logic valid_nxt;
  pix_t edge_r;
  logic last_r;

  always_comb begin
    gx = right_col.top - left_col.top
       - {left_col.mid[PIX_BITS-2:0], 1'b0} + {right_col.mid[PIX_BITS-2:0], 1'b0}
       - left_col.bot + right_col.bot;
    gy = left_col.top + {center_col.top[PIX_BITS-2:0], 1'b0} + right_col.top
       - left_col.bot - {center_col.bot[PIX_BITS-2:0], 1'b0} - right_col.bot;
    edge_sum = gx + gy;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.take) begin
      valid_nxt = ctl.emit;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take && ctl.emit) begin
      edge_r <= edge_sum;
      last_r <= ctl.last;
    end
  end

  assign out_valid         = valid_r;
  assign out_edge_value    = edge_r;
  assign out_last_of_frame = last_r;

endmodule

`default_nettype wire

// File: rtl/core/sobel_edge_window.sv
// Streaming 3x3 Sobel edge window. Takes one 8-bit gray pixel per clock in
// raster order and, once a pixel closes a full 3x3 window, delivers one edge
// value (horizontal plus vertical Sobel sum, modulo 256) in the next cycle;
// the last value of a frame carries last_of_frame. Sustained rate is one
// pixel per clock: a new pixel is taken whenever the output register is
// empty or being drained in the same cycle. The two line stores are
// registered-read RAMs whose next entry is fetched ahead through col_nxt, so no
// stall is needed between pixels. Line stores need no clearing after reset.
// Registers: line_width at 0x0, frame_height at 0x4.
// Depends on sobw_pkg, sobw_ram, sobw_cell, sobw_kernel and the defines header.
`default_nettype none

`include "sobel_edge_window_defines.svh"

module sobel_edge_window #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  sobw_pkg::pix_t                       in_pixel,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output sobw_pkg::pix_t                       out_edge_value,
  output logic                                 out_last_of_frame,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [sobw_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [sobw_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  output logic [sobw_pkg::CFG_DATA_BITS-1:0]   cfg_prdata,
  output logic                                 cfg_pready
);
  import sobw_pkg::*;

  localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW_RAW = $clog2(MAX_WIDTH + 1);
  localparam int WW     = (WW_RAW > LW_BITS) ? WW_RAW : LW_BITS;
  localparam int REG_SEL_BIT = 2;

  logic [LW_BITS-1:0] line_width_r;
  logic [FH_BITS-1:0] frame_height_r;
  logic               cfg_wr;

  logic [CW-1:0]      col_r;
  logic [CW-1:0]      col_nxt;
  logic [FH_BITS-1:0] row_r;
  logic [FH_BITS-1:0] row_nxt;

  logic [WW-1:0]      lw_ext;
  logic [WW-1:0]      width_eff;
  logic [FH_BITS-1:0] height_eff;
  logic [WW-1:0]      col_ext;
  logic [WW-1:0]      col_inc;
  logic [FH_BITS:0]   row_inc;
  logic               col_wrap;
  logic               row_wrap;

  logic               take;
  sobw_ctl_t          ctl;
  pix_t               rd_one;
  pix_t               rd_two;
  sobw_col_t          new_col;
  sobw_col_t          center_col;
  sobw_col_t          left_col;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LW_BITS'(64);
      frame_height_r <= FH_BITS'(64);
    end else if (cfg_wr) begin
      case (sobw_reg_t'(cfg_paddr[REG_SEL_BIT]))
        REG_LINE_WIDTH:   line_width_r   <= cfg_pwdata[LW_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[FH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sobw_reg_t'(cfg_paddr[REG_SEL_BIT]))
      REG_LINE_WIDTH:   cfg_prdata = CFG_DATA_BITS'(line_width_r);
      REG_FRAME_HEIGHT: cfg_prdata = CFG_DATA_BITS'(frame_height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // frame geometry and position
  always_comb begin
    lw_ext = WW'(line_width_r);
    if (lw_ext < WW'(MIN_DIM)) begin
      width_eff = WW'(MIN_DIM);
    end else if (lw_ext > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = lw_ext;
    end
    if (frame_height_r < FH_BITS'(MIN_DIM)) begin
      height_eff = FH_BITS'(MIN_DIM);
    end else begin
      height_eff = frame_height_r;
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    col_ext  = WW'(col_r);
    col_inc  = col_ext + WW'(1);
    row_inc  = {1'b0, row_r} + (FH_BITS + 1)'(1);
    col_wrap = col_inc >= width_eff;
    row_wrap = row_inc >= {1'b0, height_eff};

    col_nxt = col_r;
    row_nxt = row_r;
    if (take) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_inc[FH_BITS-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end

    ctl.take = take;
    ctl.emit = (col_ext >= WW'(WIN_SPAN)) && (row_r >= FH_BITS'(WIN_SPAN))
            && (col_ext < width_eff) && (row_r < height_eff);
    ctl.last = (row_r == height_eff - FH_BITS'(1)) && (col_ext == width_eff - WW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line stores: write the current column, fetch the next one
  sobw_ram #(
    .WIDTH (PIX_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_one_up (
    .clk     (clk),
    .wr_en   (take),
    .wr_addr (col_r),
    .wr_data (in_pixel),
    .rd_addr (col_nxt),
    .rd_data (rd_one)
  );

  sobw_ram #(
    .WIDTH (PIX_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_two_up (
    .clk     (clk),
    .wr_en   (take),
    .wr_addr (col_r),
    .wr_data (rd_one),
    .rd_addr (col_nxt),
    .rd_data (rd_two)
  );

  assign new_col.top = rd_two;
  assign new_col.mid = rd_one;
  assign new_col.bot = in_pixel;

  // window columns
  sobw_cell u_cell_center (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (take),
    .col_in   (new_col),
    .col_out  (center_col)
  );

  sobw_cell u_cell_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (take),
    .col_in   (center_col),
    .col_out  (left_col)
  );

  sobw_kernel u_kernel (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .left_col          (left_col),
    .center_col        (center_col),
    .right_col         (new_col),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_edge_value    (out_edge_value),
    .out_last_of_frame (out_last_of_frame)
  );

  `SOBW_ASSERT_SAME(a_stall_blocks_input, out_valid && !out_ready, !in_ready)
  `SOBW_ASSERT_NEXT(a_last_restarts_frame, take && ctl.emit && ctl.last,
                    col_r == '0 && row_r == '0)
  `SOBW_ASSERT_NEXT(a_no_result_no_valid, take && !ctl.emit, !out_valid)

endmodule

`default_nettype wire
